/* rtl/hal_pkg.sv */
// shared types, constants and saturating helpers for the homography affine linearizer
package hal_pkg;

    localparam logic [2:0] CFG_LIN_TOP    = 3'd0;
    localparam logic [2:0] CFG_LIN_BOTTOM = 3'd1;
    localparam logic [2:0] CFG_TRANS      = 3'd2;
    localparam logic [2:0] CFG_PERSP      = 3'd3;
    localparam logic [2:0] CFG_SCALE      = 3'd4;

    localparam int VEGA = 5;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] R_NUM   = 64'(VEGA) << 47;
    localparam logic signed [63:0] R_BIAS  = 64'(VEGA) << 16;
    localparam logic signed [63:0] ONE_40  = 64'sd1 << 40;
    localparam logic [48:0]        TOTAL_MAX = {1'b0, {48{1'b1}}};

    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
        logic signed [31:0] h02;
        logic signed [31:0] h12;
        logic signed [31:0] h20;
        logic signed [31:0] h21;
        logic signed [31:0] h22;
    } hom_cfg_t;

    typedef struct packed {
        logic signed [16:0] ax;
        logic signed [16:0] ay;
        logic [48:0]        d2;
        logic               last;
    } anchor_item_t;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic               use_shift;
        logic [6:0]         shamt;
    } md_req_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            s = a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/homography_affine_linearizer.sv */
// top level: configuration registers, front stages, queue and sequencer
//
//  channel | signals                                   | beat taken when
//  in      | in_valid, in_stall, center_*, anchor_*,   | in_valid & !in_stall
//          | last_anchor                               |
//  out     | out_valid, out_stall, a_*, weights_vanished| out_valid & !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// each anchor with a nonzero denominator uses the shared multiply-divide unit in the
// sequencer for 7 divisions and 22 multiplies
// the last anchor of a run adds 6 divisions for the result
// the two front stages and the two-entry queue take anchors while the sequencer works
// reset clears the accumulators and loads the identity homography
// a held result blocks only the next run's final division, not accumulation
module homography_affine_linearizer
    import hal_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic signed [23:0] anchor_x,
    input  logic signed [23:0] anchor_y,
    input  logic               last_anchor,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] a_xx,
    output logic signed [31:0] a_xy,
    output logic signed [31:0] a_xt,
    output logic signed [31:0] a_yx,
    output logic signed [31:0] a_yy,
    output logic signed [31:0] a_yt,
    output logic               weights_vanished
);

    logic [63:0]        lin_top_reg, lin_bot_reg, trans_reg, persp_reg;
    logic signed [31:0] scale_reg;
    hom_cfg_t           cfg;
    logic               q_push, q_pop, q_full, q_empty;
    anchor_item_t       q_wdata, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_top_reg <= 64'h0100_0000_0000_0000;
            lin_bot_reg <= 64'h0000_0000_0100_0000;
            trans_reg   <= '0;
            persp_reg   <= '0;
            scale_reg   <= 32'sh0100_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LIN_TOP:    lin_top_reg <= cfg_data;
                CFG_LIN_BOTTOM: lin_bot_reg <= cfg_data;
                CFG_TRANS:      trans_reg   <= cfg_data;
                CFG_PERSP:      persp_reg   <= cfg_data;
                CFG_SCALE:      scale_reg   <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    assign cfg.h00 = lin_top_reg[63:32];
    assign cfg.h01 = lin_top_reg[31:0];
    assign cfg.h10 = lin_bot_reg[63:32];
    assign cfg.h11 = lin_bot_reg[31:0];
    assign cfg.h02 = trans_reg[63:32];
    assign cfg.h12 = trans_reg[31:0];
    assign cfg.h20 = persp_reg[63:32];
    assign cfg.h21 = persp_reg[31:0];
    assign cfg.h22 = scale_reg;

    hal_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .center_x    (center_x),
        .center_y    (center_y),
        .anchor_x    (anchor_x),
        .anchor_y    (anchor_y),
        .last_anchor (last_anchor),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    hal_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    hal_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .a_xx             (a_xx),
        .a_xy             (a_xy),
        .a_xt             (a_xt),
        .a_yx             (a_yx),
        .a_yy             (a_yy),
        .a_yt             (a_yt),
        .weights_vanished (weights_vanished)
    );

endmodule

/* rtl/hal_front.sv */
// front stages: anchor rounding, offsets to the centre and squared distance
module hal_front
    import hal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  center_x,
    input  logic signed [15:0]  center_y,
    input  logic signed [23:0]  anchor_x,
    input  logic signed [23:0]  anchor_y,
    input  logic                last_anchor,
    input  logic                q_full,
    output logic                q_push,
    output anchor_item_t        q_data
);

    logic               v1_reg, v2_reg;
    logic signed [16:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [47:0]        sqx_reg, sqy_reg;
    logic               last1_reg, last2_reg;
    logic               s1_move, s2_move, s2_free, s1_free;
    logic signed [16:0] ax_rnd, ay_rnd;
    logic signed [49:0] sqx_full, sqy_full;

    // round q16.8 to nearest, ties to even
    function automatic logic signed [16:0] rnd_even(input logic signed [23:0] q);
        logic signed [16:0] base;
        logic               inc;
        base = 17'($signed(q[23:8]));
        inc = (q[7:0] > 8'd128) || (q[7:0] == 8'd128 && q[8]);
        return base + 17'(inc);
    endfunction

    assign ax_rnd = rnd_even(anchor_x);
    assign ay_rnd = rnd_even(anchor_y);

    assign s2_move  = v2_reg && !q_full;
    assign s2_free  = !v2_reg || s2_move;
    assign s1_move  = v1_reg && s2_free;
    assign s1_free  = !v1_reg || s1_move;
    assign in_stall = !s1_free;

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                v1_reg <= in_valid;
            if (s2_free)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            ax1_reg   <= ax_rnd;
            ay1_reg   <= ay_rnd;
            dx_reg    <= (25'(center_x) <<< 8) - 25'(anchor_x);
            dy_reg    <= (25'(center_y) <<< 8) - 25'(anchor_y);
            last1_reg <= last_anchor;
        end
        if (s1_move)
        begin
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            sqx_reg   <= sqx_full[47:0];
            sqy_reg   <= sqy_full[47:0];
            last2_reg <= last1_reg;
        end
    end

    assign q_push      = s2_move;
    assign q_data.ax   = ax2_reg;
    assign q_data.ay   = ay2_reg;
    assign q_data.d2   = 49'(sqx_reg) + 49'(sqy_reg);
    assign q_data.last = last2_reg;

endmodule

/* rtl/hal_fifo.sv */
// two-entry queue between the front stages and the sequencer
module hal_fifo
    import hal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  anchor_item_t push_data,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output anchor_item_t head
);

    anchor_item_t mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/hal_muldiv.sv */
// shared multiply-divide unit: trunc(a*b/c) or trunc(a*b/2^k), saturated to 64 bits
module hal_muldiv
    import hal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  md_req_t            req,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] result
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_FIN  = 2'd3;

    logic [1:0]         state_reg;
    logic [6:0]         cnt_reg;
    logic [63:0]        x_reg, y_reg, d_reg, rem_reg, pp_reg;
    logic [127:0]       prod_reg;
    logic               neg_reg, shift_reg, done_reg;
    logic [6:0]         shamt_reg;
    logic signed [63:0] result_reg;

    logic [31:0]        xi, yi;
    logic [63:0]        pp_next;
    logic [1:0]         pidx;
    logic [127:0]       pp_shifted, quot;
    logic [64:0]        rem2, diff;
    logic               ge;
    logic signed [63:0] sat_q;

    always_comb
    begin
        xi      = cnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
        yi      = cnt_reg[1] ? y_reg[63:32] : y_reg[31:0];
        pp_next = xi * yi;
        pidx    = 2'(cnt_reg - 7'd1);
        unique case (pidx)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1,
            2'd2:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
        rem2 = {rem_reg, prod_reg[127]};
        diff = rem2 - {1'b0, d_reg};
        ge   = rem2 >= {1'b0, d_reg};
        quot = shift_reg ? (prod_reg >> shamt_reg) : prod_reg;
        if (!shift_reg && d_reg == 64'd0)
            sat_q = '0;
        else if (neg_reg)
        begin
            if (quot[127:64] != 64'd0 || quot[63:0] > 64'h8000_0000_0000_0000)
                sat_q = S64_MIN;
            else
                sat_q = -$signed(quot[63:0]);
        end
        else
        begin
            if (quot[127:63] != 65'd0)
                sat_q = S64_MAX;
            else
                sat_q = $signed(quot[63:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= MD_MUL;
                        cnt_reg   <= '0;
                    end
                end
                MD_MUL:
                begin
                    if (cnt_reg == 7'd4)
                    begin
                        cnt_reg <= '0;
                        if (!shift_reg && d_reg != 64'd0)
                            state_reg <= MD_DIV;
                        else
                            state_reg <= MD_FIN;
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                MD_DIV:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                        state_reg <= MD_FIN;
                end
                default:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MD_IDLE && start)
        begin
            x_reg     <= mag64(req.a);
            y_reg     <= mag64(req.b);
            d_reg     <= mag64(req.c);
            neg_reg   <= (req.a[63] ^ req.b[63]) ^ req.c[63];
            shift_reg <= req.use_shift;
            shamt_reg <= req.shamt;
            prod_reg  <= '0;
            rem_reg   <= '0;
        end
        if (state_reg == MD_MUL)
        begin
            // partial products: one 32x32 multiply per beat, registered and then added into the product
            if (cnt_reg != 7'd4)
                pp_reg <= pp_next;
            if (cnt_reg != 7'd0)
                prod_reg <= prod_reg + pp_shifted;
        end
        if (state_reg == MD_DIV)
        begin
            rem_reg  <= ge ? diff[63:0] : rem2[63:0];
            prod_reg <= {prod_reg[126:0], ge};
        end
        if (state_reg == MD_FIN)
            result_reg <= sat_q;
    end

    assign busy   = state_reg != MD_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/hal_back.sv */
// sequencer: weight, taylor terms, accumulation and final division per run
module hal_back
    import hal_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  hom_cfg_t           cfg,
    input  logic               q_empty,
    input  anchor_item_t       q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] a_xx,
    output logic signed [31:0] a_xy,
    output logic signed [31:0] a_xt,
    output logic signed [31:0] a_yx,
    output logic signed [31:0] a_yy,
    output logic signed [31:0] a_yt,
    output logic               weights_vanished
);

    localparam int SH_R = (WEIGHT_FRAC_BITS <= 31) ? 31 - WEIGHT_FRAC_BITS : 0;
    localparam int SH_L = (WEIGHT_FRAC_BITS > 31) ? WEIGHT_FRAC_BITS - 31 : 0;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ISSUE = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_OUTW  = 2'd3;

    localparam logic [5:0] ST_R     = 6'd0;
    localparam logic [5:0] ST_R2    = 6'd1;
    localparam logic [5:0] ST_R3    = 6'd2;
    localparam logic [5:0] ST_DEN0  = 6'd3;
    localparam logic [5:0] ST_DEN1  = 6'd4;
    localparam logic [5:0] ST_NX0   = 6'd5;
    localparam logic [5:0] ST_NX1   = 6'd6;
    localparam logic [5:0] ST_NY0   = 6'd7;
    localparam logic [5:0] ST_NY1   = 6'd8;
    localparam logic [5:0] ST_Y1    = 6'd9;
    localparam logic [5:0] ST_Y2    = 6'd10;
    localparam logic [5:0] ST_T_XX  = 6'd11;
    localparam logic [5:0] ST_J_XX  = 6'd12;
    localparam logic [5:0] ST_T_XY  = 6'd13;
    localparam logic [5:0] ST_J_XY  = 6'd14;
    localparam logic [5:0] ST_T_YX  = 6'd15;
    localparam logic [5:0] ST_J_YX  = 6'd16;
    localparam logic [5:0] ST_T_YY  = 6'd17;
    localparam logic [5:0] ST_J_YY  = 6'd18;
    localparam logic [5:0] ST_TX0   = 6'd19;
    localparam logic [5:0] ST_TX1   = 6'd20;
    localparam logic [5:0] ST_TY0   = 6'd21;
    localparam logic [5:0] ST_TY1   = 6'd22;
    localparam logic [5:0] ST_ACC0  = 6'd23;
    localparam logic [5:0] ST_ACC5  = 6'd28;
    localparam logic [5:0] ST_RES0  = 6'd29;
    localparam logic [5:0] ST_RES5  = 6'd34;

    logic [1:0]         phase_reg;
    logic [5:0]         step_reg;
    anchor_item_t       item_reg;
    logic signed [63:0] r_reg, r2_reg, w_reg, den_reg, nx_reg, ny_reg;
    logic signed [63:0] y1_reg, y2_reg, t_reg;
    logic signed [63:0] term_reg [6];
    logic signed [63:0] acc_reg [6];
    logic [47:0]        total_reg;
    logic signed [31:0] out_reg [6];
    logic               out_valid_reg, vanished_reg;

    md_req_t            md_req;
    logic               md_start, md_busy, md_done;
    logic signed [63:0] md_res;
    logic signed [63:0] ax64, ay64;
    logic [2:0]         acc_k, res_k;
    logic [48:0]        total_sum;
    logic               emit_now;

    assign ax64  = 64'(item_reg.ax);
    assign ay64  = 64'(item_reg.ay);
    assign acc_k = 3'(step_reg - ST_ACC0);
    assign res_k = 3'(step_reg - ST_RES0);
    assign total_sum = 49'(total_reg) + 49'(w_reg);

    hal_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .req    (md_req),
        .busy   (md_busy),
        .done   (md_done),
        .result (md_res)
    );

    function automatic md_req_t mk_mul(input logic signed [63:0] a,
                                       input logic signed [63:0] b,
                                       input logic [6:0] sh);
        md_req_t q;
        q.a = a;
        q.b = b;
        q.c = 64'sd1;
        q.use_shift = 1'b1;
        q.shamt = sh;
        return q;
    endfunction

    function automatic md_req_t mk_div(input logic signed [63:0] a,
                                       input logic signed [63:0] b,
                                       input logic signed [63:0] c);
        md_req_t q;
        q.a = a;
        q.b = b;
        q.c = c;
        q.use_shift = 1'b0;
        q.shamt = '0;
        return q;
    endfunction

    always_comb
    begin
        md_start = phase_reg == PH_ISSUE;
        case (step_reg)
            ST_R:    md_req = mk_div(R_NUM, 64'sd1, R_BIAS + 64'(item_reg.d2));
            ST_R2:   md_req = mk_mul(r_reg, r_reg, 7'd31);
            ST_R3:   md_req = mk_mul(r2_reg, r_reg, 7'd31);
            ST_DEN0: md_req = mk_mul(64'(cfg.h20), ax64, 7'd0);
            ST_DEN1: md_req = mk_mul(64'(cfg.h21), ay64, 7'd0);
            ST_NX0:  md_req = mk_mul(64'(cfg.h00), ax64, 7'd0);
            ST_NX1:  md_req = mk_mul(64'(cfg.h01), ay64, 7'd0);
            ST_NY0:  md_req = mk_mul(64'(cfg.h10), ax64, 7'd0);
            ST_NY1:  md_req = mk_mul(64'(cfg.h11), ay64, 7'd0);
            ST_Y1:   md_req = mk_div(nx_reg, ONE_40, den_reg);
            ST_Y2:   md_req = mk_div(ny_reg, ONE_40, den_reg);
            ST_T_XX: md_req = mk_mul(64'(cfg.h20), y1_reg, 7'd40);
            ST_J_XX: md_req = mk_div(sat_sub(64'(cfg.h00), t_reg), ONE_40, den_reg);
            ST_T_XY: md_req = mk_mul(64'(cfg.h21), y1_reg, 7'd40);
            ST_J_XY: md_req = mk_div(sat_sub(64'(cfg.h01), t_reg), ONE_40, den_reg);
            ST_T_YX: md_req = mk_mul(64'(cfg.h20), y2_reg, 7'd40);
            ST_J_YX: md_req = mk_div(sat_sub(64'(cfg.h10), t_reg), ONE_40, den_reg);
            ST_T_YY: md_req = mk_mul(64'(cfg.h21), y2_reg, 7'd40);
            ST_J_YY: md_req = mk_div(sat_sub(64'(cfg.h11), t_reg), ONE_40, den_reg);
            ST_TX0:  md_req = mk_mul(ax64, term_reg[0], 7'd0);
            ST_TX1:  md_req = mk_mul(ay64, term_reg[1], 7'd0);
            ST_TY0:  md_req = mk_mul(ax64, term_reg[3], 7'd0);
            ST_TY1:  md_req = mk_mul(ay64, term_reg[4], 7'd0);
            default:
            begin
                if (step_reg <= ST_ACC5)
                    md_req = mk_mul(w_reg, term_reg[acc_k], 7'd0);
                else if (res_k == 3'd2 || res_k == 3'd5)
                    md_req = mk_div(acc_reg[res_k], 64'sd1, 64'(total_reg) << 12);
                else
                    md_req = mk_div(acc_reg[res_k], 64'sd1, 64'(total_reg));
            end
        endcase
    end

    assign q_pop = phase_reg == PH_IDLE && !q_empty;

    // run ends either with vanished weights or after the last coefficient
    assign emit_now = (phase_reg == PH_OUTW && !out_valid_reg && total_reg == '0) ||
                      (phase_reg == PH_WAIT && md_done && step_reg == ST_RES5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= ST_R;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            for (int k = 0; k < 6; k++)
                acc_reg[k] <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (!q_empty)
                    begin
                        phase_reg <= PH_ISSUE;
                        step_reg  <= ST_R;
                    end
                end
                PH_ISSUE:
                    phase_reg <= PH_WAIT;
                PH_WAIT:
                begin
                    if (md_done)
                    begin
                        if (step_reg == ST_ACC5)
                            phase_reg <= item_reg.last ? PH_OUTW : PH_IDLE;
                        else if (step_reg != ST_RES5)
                            phase_reg <= PH_ISSUE;
                        if (step_reg == ST_NY1 && den_reg == '0)
                            step_reg <= ST_ACC0;
                        else
                            step_reg <= step_reg + 6'd1;
                        if (step_reg == ST_ACC0)
                            total_reg <= (total_sum > TOTAL_MAX) ? TOTAL_MAX[47:0]
                                                                 : total_sum[47:0];
                        if (step_reg >= ST_ACC0 && step_reg <= ST_ACC5)
                            acc_reg[acc_k] <= sat_add(acc_reg[acc_k], md_res);
                    end
                end
                default:
                begin
                    if (!out_valid_reg && total_reg != '0)
                    begin
                        phase_reg <= PH_ISSUE;
                        step_reg  <= ST_RES0;
                    end
                end
            endcase
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= PH_IDLE;
                total_reg     <= '0;
                for (int k = 0; k < 6; k++)
                    acc_reg[k] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_head;
        if (phase_reg == PH_OUTW && !out_valid_reg && total_reg == '0)
        begin
            vanished_reg <= 1'b1;
            for (int k = 0; k < 6; k++)
                out_reg[k] <= '0;
        end
        if (phase_reg == PH_WAIT && md_done)
        begin
            unique case (step_reg)
                ST_R:    r_reg   <= md_res;
                ST_R2:   r2_reg  <= md_res;
                ST_R3:   w_reg   <= (md_res >> SH_R) << SH_L;
                ST_DEN0: den_reg <= (64'(cfg.h22) <<< 16) + md_res;
                ST_DEN1: den_reg <= den_reg + md_res;
                ST_NX0:  nx_reg  <= (64'(cfg.h02) <<< 12) + md_res;
                ST_NX1:  nx_reg  <= nx_reg + md_res;
                ST_NY0:  ny_reg  <= (64'(cfg.h12) <<< 12) + md_res;
                ST_NY1:
                begin
                    ny_reg <= ny_reg + md_res;
                    if (den_reg == '0)
                        for (int k = 0; k < 6; k++)
                            term_reg[k] <= '0;
                end
                ST_Y1:   y1_reg <= md_res;
                ST_Y2:   y2_reg <= md_res;
                ST_T_XX, ST_T_XY, ST_T_YX, ST_T_YY: t_reg <= md_res;
                ST_J_XX: term_reg[0] <= md_res;
                ST_J_XY: term_reg[1] <= md_res;
                ST_J_YX: term_reg[3] <= md_res;
                ST_J_YY: term_reg[4] <= md_res;
                ST_TX0:  term_reg[2] <= sat_sub(y1_reg, md_res);
                ST_TX1:  term_reg[2] <= sat_sub(term_reg[2], md_res);
                ST_TY0:  term_reg[5] <= sat_sub(y2_reg, md_res);
                ST_TY1:  term_reg[5] <= sat_sub(term_reg[5], md_res);
                default:
                begin
                    if (step_reg >= ST_RES0)
                    begin
                        out_reg[res_k] <= sat32(md_res);
                        vanished_reg   <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign a_xx             = out_reg[0];
    assign a_xy             = out_reg[1];
    assign a_xt             = out_reg[2];
    assign a_yx             = out_reg[3];
    assign a_yy             = out_reg[4];
    assign a_yt             = out_reg[5];
    assign weights_vanished = vanished_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        md_start |-> !md_busy)
        else $error("multiply-divide started while busy");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |=> (total_reg == '0 && acc_reg[0] == '0 && acc_reg[5] == '0))
        else $error("accumulators not cleared after a result");

    a_vanished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && vanished_reg) |-> (out_reg[0] == '0 && out_reg[2] == '0 &&
                                             out_reg[4] == '0 && out_reg[5] == '0))
        else $error("vanished weights with nonzero coefficients");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT && step_reg >= ST_RES0) |-> !out_valid_reg)
        else $error("result register written while still held");

endmodule

/* verif/testbench.sv */
// testbench for the homography affine linearizer: directed table, random runs, scoreboard
module testbench;

    localparam int          WFRAC     = 24;
    localparam longint      CYCLE_CAP = 12_000_000;
    localparam int          HOLD_LEN  = 30000;
    localparam logic signed [63:0] I64_HI = 64'h7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] I64_LO = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] ONE40  = 64'sd1 << 40;
    localparam logic [63:0]        TOT_CAP = 64'h0000_ffff_ffff_ffff;

    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] xy;
        logic signed [31:0] xt;
        logic signed [31:0] yx;
        logic signed [31:0] yy;
        logic signed [31:0] yt;
        logic               vanished;
    } affine_t;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic               last;
        logic               typed;
        affine_t            want;
    } anchor_t;

    localparam affine_t IDENT_FIT  = '{32'sh0100_0000, 0, 0, 0, 32'sh0100_0000, 0, 1'b0};
    localparam affine_t NO_WEIGHT  = '{0, 0, 0, 0, 0, 0, 1'b1};
    localparam affine_t FLAT_FIT   = '{0, 0, 0, 0, 0, 0, 1'b0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    anchor_t cur = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] a_xx, a_xy, a_xt, a_yx, a_yy, a_yt;
    logic weights_vanished;

    homography_affine_linearizer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .center_x(cur.cx), .center_y(cur.cy), .anchor_x(cur.ax), .anchor_y(cur.ay),
        .last_anchor(cur.last),
        .out_valid(out_valid), .out_stall(out_stall),
        .a_xx(a_xx), .a_xy(a_xy), .a_xt(a_xt), .a_yx(a_yx), .a_yy(a_yy), .a_yt(a_yt),
        .weights_vanished(weights_vanished)
    );

    // homography copy and accumulators of the predictor
    logic [63:0]        hom_top, hom_bot, hom_trans, hom_persp;
    logic signed [31:0] hom_scale;
    logic signed [63:0] acc_terms [6];
    logic [63:0]        acc_weight;

    anchor_t stim_q [$];
    affine_t fit_q [$];
    int      errs = 0;
    int      fits_seen = 0;
    int      beats_taken = 0;
    int      vanished_seen = 0;
    int      src_idle = 0;
    int      snk_idle = 0;
    logic    hold_go = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_left = 0;
    longint  cycles = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] absval(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // trunc(a*b/c) on a 128-bit product, clipped to 64 bits; zero divisor gives zero
    function automatic logic signed [63:0] scale_div(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input logic signed [63:0] c);
        logic [127:0] p, q;
        logic neg;
        if (c == 0)
            return 0;
        neg = a[63] ^ b[63] ^ c[63];
        p = {64'd0, absval(a)} * {64'd0, absval(b)};
        q = p / {64'd0, absval(c)};
        if (neg) begin
            if (q >= 128'h8000_0000_0000_0000)
                return I64_LO;
            return 64'(-q[63:0]);
        end
        if (q > 128'h7fff_ffff_ffff_ffff)
            return I64_HI;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] clip_add(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? I64_LO : I64_HI;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clip_sub(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63])
            return s[64] ? I64_LO : I64_HI;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // nearest integer pixel, ties to even
    function automatic logic signed [63:0] pixel_of(input logic signed [23:0] q);
        logic signed [63:0] b;
        logic [7:0] f;
        f = q[7:0];
        b = 64'(q);
        b = b >>> 8;
        if (f > 8'd128 || (f == 8'd128 && b[0]))
            b = b + 1;
        return b;
    endfunction

    function automatic logic [63:0] falloff(input logic signed [15:0] cx,
                                            input logic signed [15:0] cy,
                                            input logic signed [23:0] ax,
                                            input logic signed [23:0] ay);
        logic signed [63:0] dx, dy;
        logic [63:0] d2, r, r2, r3;
        dx = 64'(cx);
        dx = dx * 256 - 64'(ax);
        dy = 64'(cy);
        dy = dy * 256 - 64'(ay);
        d2 = dx * dx + dy * dy;
        r  = (64'd5 << 47) / ((64'd5 << 16) + d2);
        r2 = (r * r) >> 31;
        r3 = (r2 * r) >> 31;
        return WFRAC <= 31 ? r3 >> (31 - WFRAC) : r3 << (WFRAC - 31);
    endfunction

    task automatic fit_anchor(input anchor_t b, output logic emit, output affine_t res);
        logic signed [63:0] h00, h01, h10, h11, h02, h12, h20, h21, h22;
        logic signed [63:0] px, py, den, nx, ny, y1, y2, v, dv;
        logic signed [63:0] t [6];
        logic [63:0] w;
        logic signed [31:0] o [6];
        h00 = 64'($signed(hom_top[63:32]));   h01 = 64'($signed(hom_top[31:0]));
        h10 = 64'($signed(hom_bot[63:32]));   h11 = 64'($signed(hom_bot[31:0]));
        h02 = 64'($signed(hom_trans[63:32])); h12 = 64'($signed(hom_trans[31:0]));
        h20 = 64'($signed(hom_persp[63:32])); h21 = 64'($signed(hom_persp[31:0]));
        h22 = 64'(hom_scale);
        px = pixel_of(b.ax);
        py = pixel_of(b.ay);
        w = falloff(b.cx, b.cy, b.ax, b.ay);
        den = h22 * 65536 + h20 * px + h21 * py;
        for (int k = 0; k < 6; k++)
            t[k] = 0;
        if (den != 0) begin
            nx = h02 * 4096 + h00 * px + h01 * py;
            ny = h12 * 4096 + h10 * px + h11 * py;
            y1 = scale_div(nx, ONE40, den);
            y2 = scale_div(ny, ONE40, den);
            t[0] = scale_div(clip_sub(h00, scale_div(h20, y1, ONE40)), ONE40, den);
            t[1] = scale_div(clip_sub(h01, scale_div(h21, y1, ONE40)), ONE40, den);
            t[3] = scale_div(clip_sub(h10, scale_div(h20, y2, ONE40)), ONE40, den);
            t[4] = scale_div(clip_sub(h11, scale_div(h21, y2, ONE40)), ONE40, den);
            t[2] = clip_sub(clip_sub(y1, scale_div(px, t[0], 1)), scale_div(py, t[1], 1));
            t[5] = clip_sub(clip_sub(y2, scale_div(px, t[3], 1)), scale_div(py, t[4], 1));
        end
        for (int k = 0; k < 6; k++)
            acc_terms[k] = clip_add(acc_terms[k], scale_div($signed(w), t[k], 1));
        acc_weight = (acc_weight + w > TOT_CAP) ? TOT_CAP : acc_weight + w;
        emit = b.last;
        res = '0;
        if (!b.last)
            return;
        for (int k = 0; k < 6; k++) begin
            v = 0;
            if (acc_weight != 0) begin
                dv = $signed(acc_weight);
                if (k == 2 || k == 5)
                    dv = dv * 4096;
                v = clip32(scale_div(acc_terms[k], 1, dv));
            end
            o[k] = v[31:0];
            acc_terms[k] = 0;
        end
        res = '{o[0], o[1], o[2], o[3], o[4], o[5], acc_weight == 0};
        acc_weight = 0;
    endtask

    // input side: offer queued beats, hold payload while stalled
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall) begin
            if (stim_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                cur <= stim_q.pop_front();
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: random stall, plus one long hold-off that backs the block up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    always @(posedge clk) begin
        logic emit;
        affine_t res, exp_fit;
        if (rst_n && in_valid && !in_stall) begin
            beats_taken++;
            fit_anchor(cur, emit, res);
            if (emit)
                fit_q.push_back(cur.typed ? cur.want : res);
        end
        if (rst_n && out_valid && !out_stall) begin
            fits_seen++;
            if (weights_vanished)
                vanished_seen++;
            if (fit_q.size() == 0) begin
                $error("result beat with nothing expected");
                errs++;
            end
            else begin
                exp_fit = fit_q.pop_front();
                if (a_xx !== exp_fit.xx) begin
                    $error("a_xx expected %0d got %0d", exp_fit.xx, a_xx); errs++;
                end
                if (a_xy !== exp_fit.xy) begin
                    $error("a_xy expected %0d got %0d", exp_fit.xy, a_xy); errs++;
                end
                if (a_xt !== exp_fit.xt) begin
                    $error("a_xt expected %0d got %0d", exp_fit.xt, a_xt); errs++;
                end
                if (a_yx !== exp_fit.yx) begin
                    $error("a_yx expected %0d got %0d", exp_fit.yx, a_yx); errs++;
                end
                if (a_yy !== exp_fit.yy) begin
                    $error("a_yy expected %0d got %0d", exp_fit.yy, a_yy); errs++;
                end
                if (a_yt !== exp_fit.yt) begin
                    $error("a_yt expected %0d got %0d", exp_fit.yt, a_yt); errs++;
                end
                if (weights_vanished !== exp_fit.vanished) begin
                    $error("weights_vanished expected %0d got %0d",
                           exp_fit.vanished, weights_vanished);
                    errs++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic anchor_t mk(input int cx, input int cy, input int ax, input int ay,
                                   input logic last, input logic typed, input affine_t want);
        anchor_t b;
        b.cx = 16'(cx); b.cy = 16'(cy); b.ax = 24'(ax); b.ay = 24'(ay);
        b.last = last; b.typed = typed; b.want = want;
        return b;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hal_pkg::CFG_LIN_TOP:    hom_top   = val;
            hal_pkg::CFG_LIN_BOTTOM: hom_bot   = val;
            hal_pkg::CFG_TRANS:      hom_trans = val;
            hal_pkg::CFG_PERSP:      hom_persp = val;
            hal_pkg::CFG_SCALE:      hom_scale = val[31:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do begin
            @(posedge clk);
            #1;
        end while (stim_q.size() > 0 || in_valid || fit_q.size() > 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic int srand(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic [63:0] pair(input int hi, input int lo);
        return {hi[31:0], lo[31:0]};
    endfunction

    task automatic load_homography(input int p);
        int kind;
        logic [63:0] v [5];
        kind = p == 1 ? 0 : p == 2 ? 1 : p == 3 ? 3 : $urandom_range(0, 11);
        case (kind)
            0: begin
                for (int k = 0; k < 5; k++)
                    v[k] = '1;
            end
            1: begin
                v[0] = 64'h7fff_ffff_8000_0000;
                v[1] = 64'h8000_0000_7fff_ffff;
                v[2] = 64'h7fff_ffff_8000_0000;
                v[3] = 64'h0000_0000_0000_0000;
                v[4] = 64'h0000_0000_0000_0001;
            end
            2: begin
                for (int k = 0; k < 5; k++)
                    v[k] = {$urandom, $urandom};
            end
            3: begin
                // zero denominator everywhere
                v[0] = {$urandom, $urandom};
                v[1] = {$urandom, $urandom};
                v[2] = {$urandom, $urandom};
                v[3] = '0;
                v[4] = {$urandom, 32'd0};
            end
            default: begin
                v[0] = pair(32'h0100_0000 + srand(1 << 23), srand(1 << 22));
                v[1] = pair(srand(1 << 22), 32'h0100_0000 + srand(1 << 23));
                v[2] = pair(srand(1 << 24), srand(1 << 24));
                v[3] = pair(srand(1 << 26), srand(1 << 26));
                v[4] = {$urandom, 32'h0100_0000 + srand(1 << 22)};
            end
        endcase
        reg_write(hal_pkg::CFG_LIN_TOP, v[0]);
        reg_write(hal_pkg::CFG_LIN_BOTTOM, v[1]);
        reg_write(hal_pkg::CFG_TRANS, v[2]);
        reg_write(hal_pkg::CFG_PERSP, v[3]);
        reg_write(hal_pkg::CFG_SCALE, v[4]);
        // unused index, must leave everything alone
        reg_write(3'($urandom_range(5, 7)), {$urandom, $urandom});
    endtask

    function automatic anchor_t rand_anchor(input int cx, input int cy, input logic last);
        int sel;
        anchor_t b;
        sel = $urandom_range(0, 9);
        b.cx = 16'(cx);
        b.cy = 16'(cy);
        if (sel == 0) begin
            b.ax = 24'($urandom);
            b.ay = 24'($urandom);
        end
        else if (sel == 1) begin
            b.cx = 16'($urandom);
            b.cy = 16'($urandom);
            b.ax = 24'(int'(b.cx) * 256 + srand(4000));
            b.ay = 24'(int'(b.cy) * 256 + srand(4000));
        end
        else begin
            b.ax = 24'(cx * 256 + srand(sel < 4 ? 600 : 3000));
            b.ay = 24'(cy * 256 + srand(sel < 4 ? 600 : 3000));
            if (sel == 2) begin
                b.ax[7:0] = 8'h80;
                b.ay[7:0] = 8'h80;
            end
        end
        b.last = last;
        b.typed = 1'b0;
        b.want = '0;
        return b;
    endfunction

    initial begin
        int cx, cy, len, goal;
        hom_top   = 64'd72057594037927936;
        hom_bot   = 64'd16777216;
        hom_trans = '0;
        hom_persp = '0;
        hom_scale = 32'sd16777216;
        for (int k = 0; k < 6; k++)
            acc_terms[k] = 0;
        acc_weight = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // identity homography from reset: any run with weight fits the identity
        stim_q.push_back(mk(0, 0, 0, 0, 1, 1, IDENT_FIT));
        stim_q.push_back(mk(100, -50, 25600, -12800, 1, 1, IDENT_FIT));
        stim_q.push_back(mk(32767, -32768, 8388352, -8388608, 1, 1, IDENT_FIT));
        stim_q.push_back(mk(-32768, -32768, 8388607, 8388607, 1, 1, NO_WEIGHT));
        stim_q.push_back(mk(0, 0, 8388607, -8388608, 1, 1, NO_WEIGHT));
        stim_q.push_back(mk(1, 2, 'h180, 'h280, 0, 0, '0));
        stim_q.push_back(mk(2, 2, 'h280, -'h80, 0, 0, '0));
        stim_q.push_back(mk(-1, 0, -'h80, 'h7f, 1, 1, IDENT_FIT));
        stim_q.push_back(mk(-32768, 32767, 8388607, -8388608, 0, 0, '0));
        stim_q.push_back(mk(10, 10, 2560, 2570, 1, 1, IDENT_FIT));
        stim_q.push_back(mk(5, -7, 1300, -1800, 0, 0, '0));
        stim_q.push_back(mk(-300, 400, -76800, 102400, 0, 0, '0));
        stim_q.push_back(mk(-300, 400, -76900, 102500, 1, 0, '0));
        drain();

        // zero denominator: terms add nothing, weight still counts
        reg_write(hal_pkg::CFG_SCALE, '0);
        stim_q.push_back(mk(0, 0, 0, 0, 1, 1, FLAT_FIT));
        stim_q.push_back(mk(3, 3, 770, 760, 0, 0, '0));
        stim_q.push_back(mk(3, 3, 700, 800, 1, 1, FLAT_FIT));
        drain();

        for (int p = 1; p <= 8; p++) begin
            case (p % 3)
                1: begin src_idle = 35; snk_idle = 79; end
                2: begin src_idle = 79; snk_idle = 35; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            load_homography(p);
            if (p == 4)
                hold_go <= 1'b1;
            goal = 150;
            while (goal > 0) begin
                len = $urandom_range(0, 7) == 0 ? $urandom_range(8, 14) : $urandom_range(1, 5);
                cx = srand(32767);
                cy = srand(32767);
                if ($urandom_range(0, 3) == 0) begin
                    cx = srand(200);
                    cy = srand(200);
                end
                for (int i = 0; i < len; i++)
                    stim_q.push_back(rand_anchor(cx, cy, i == len - 1));
                goal -= len;
            end
            drain();
        end

        repeat (300) @(posedge clk);
        $display("covered %0d anchors and %0d fits (%0d with vanished weight)",
                 beats_taken, fits_seen, vanished_seen);
        $display("across reset identity, zero denominator, extreme and random homographies");
        if (errs == 0 && fit_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
